// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- design/pmu_pkg.sv -----
`default_nettype none
package pmu_pkg;

    localparam int NUM_PARTICLES_DEF = 64;
    localparam int SUM_W             = 41;

    typedef logic [1:0] t_action;
    localparam t_action ACT_LOAD   = 2'd0;
    localparam t_action ACT_TICK   = 2'd1;
    localparam t_action ACT_CENTER = 2'd2;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_DROP   = 2'd0;
    localparam t_mode MODE_RISE   = 2'd1;
    localparam t_mode MODE_SPREAD = 2'd2;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_LOOP = 1'b1;

    typedef struct packed {
        logic [1:0]          action;
        logic [5:0]          particle_index;
        logic signed [31:0]  pos_x;
        logic signed [31:0]  pos_y;
        logic signed [31:0]  pos_z;
        logic signed [31:0]  speed_value;
        logic [31:0]         life_limit;
        logic [19:0]         time_step;
    } t_in_word;

    typedef struct packed {
        logic [5:0]          out_index;
        logic signed [31:0]  out_x;
        logic signed [31:0]  out_y;
        logic signed [31:0]  out_z;
        logic [31:0]         out_age;
        logic                restarted;
        logic                last_flag;
    } t_out_word;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] speed;
        logic [31:0]        limit;
        logic [31:0]        age;
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_LAT, S_STEP, S_YMOVE, S_DIFF, S_SQ, S_SQRT,
        S_DIV, S_MUL, S_ADD, S_APPLY
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v[SUM_W-1:31] == '0 || v[SUM_W-1:31] == '1) begin
            return v[31:0];
        end else if (v[SUM_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

endpackage
`default_nettype wire

// ----- design/particle_motion_update_unit.sv -----
`default_nettype none
// Particle table with fixed-point Euler motion. Per-slot state lives in one
// synchronous RAM word per slot (current and restart xyz, speed, limit, age),
// read, updated and written back one slot at a time, apart from a flag register
// that picks the center pivot as restart point. Load and center words yield no
// result. A tick emits one result word per slot in slot order; spread mode is
// slowest per slot (unless the particle sits on the pivot), dominated by the
// 32-step square root and three 17-step restoring divides, and the walk holds
// while the output stalls. A new input word is taken only once the tick walk is
// done; the last result may still sit in the output register.
module particle_motion_update_unit #(
    parameter int NUM_PARTICLES = pmu_pkg::NUM_PARTICLES_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  pmu_pkg::t_in_word   i_in,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output pmu_pkg::t_out_word  o_out,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire                 i_cfg_index,
    input  wire [1:0]           i_cfg_data
);
    import pmu_pkg::*;

    localparam int AW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;

    t_slot r_mem [NUM_PARTICLES];
    t_slot r_rdata;

    t_state r_state, n_state;
    t_mode  r_mode;
    logic   r_loop;
    logic [NUM_PARTICLES-1:0] r_ctr;
    logic signed [31:0] r_piv [3];

    logic [AW-1:0]       r_p;
    logic [19:0]         r_dt;
    logic signed [31:0]  r_pos [3];
    logic signed [31:0]  r_rst [3];
    logic signed [36:0]  r_step;
    logic [30:0]         r_mag [3];
    logic [2:0]          r_neg;
    logic [1:0]          r_ax;
    logic [63:0]         r_sum, r_n, r_res, r_bit;
    logic [31:0]         r_len, r_rem;
    logic [16:0]         r_q;
    logic [4:0]          r_cnt;
    logic signed [17:0]  r_u;
    logic signed [54:0]  r_prod;
    logic                r_out_valid;
    t_out_word           r_out;

    // combinational datapath
    logic               in_acc, out_free, load_ok, w_we;
    logic [AW-1:0]      w_addr;
    t_slot              w_data;
    logic signed [52:0] step_prod;
    logic signed [SUM_W-1:0] ysum, asum;
    logic signed [32:0] dif [3];
    logic [32:0]        dmag [3];
    logic [1:0]         sh;
    logic               dzero;
    logic [61:0]        sq;
    logic [63:0]        qt;
    logic [63:0]        res_nx, n_nx;
    logic [32:0]        trial;
    logic [16:0]        q_nx;
    logic [31:0]        rem_nx;
    logic signed [54:0] mv_prod;
    logic signed [38:0] mvs;
    logic [32:0]        age_sum;
    logic [31:0]        age_s;
    logic               rs;
    logic signed [31:0] fx, fy, fz;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign load_ok  = ({1'b0, i_in.particle_index} < 7'(NUM_PARTICLES));

    assign step_prod = 53'(r_rdata.speed) * 53'($signed({1'b0, r_dt}));
    assign ysum = (r_mode == MODE_DROP) ? SUM_W'(r_pos[1]) - SUM_W'(r_step)
                                        : SUM_W'(r_pos[1]) + SUM_W'(r_step);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            dif[c]  = 33'(r_pos[c]) - 33'(r_piv[c]);
            dmag[c] = dif[c][32] ? 33'(-dif[c]) : 33'(dif[c]);
        end
        dzero = (dif[0] == '0) && (dif[1] == '0) && (dif[2] == '0);
        if (dmag[0][32] || dmag[1][32] || dmag[2][32]) begin
            sh = 2'd2;
        end else if (dmag[0][31] || dmag[1][31] || dmag[2][31]) begin
            sh = 2'd1;
        end else begin
            sh = 2'd0;
        end
    end

    assign sq = 62'(r_mag[r_ax]) * 62'(r_mag[r_ax]);

    // one square-root digit
    always_comb begin
        qt = r_res + r_bit;
        if (r_n >= qt) begin
            n_nx   = r_n - qt;
            res_nx = (r_res >> 1) + r_bit;
        end else begin
            n_nx   = r_n;
            res_nx = r_res >> 1;
        end
    end

    // one quotient bit; numerator is mag << 16
    always_comb begin
        trial = {r_rem, (r_cnt == 5'd16) ? r_mag[r_ax][0] : 1'b0};
        if (trial >= {1'b0, r_len}) begin
            rem_nx = 32'(trial - {1'b0, r_len});
            q_nx   = {r_q[15:0], 1'b1};
        end else begin
            rem_nx = trial[31:0];
            q_nx   = {r_q[15:0], 1'b0};
        end
    end

    assign mv_prod = 55'(r_u) * 55'(r_step);
    assign mvs     = $signed(r_prod[54:16]);
    assign asum    = SUM_W'(r_pos[r_ax]) + SUM_W'(mvs);

    always_comb begin
        age_sum = {1'b0, r_rdata.age} + 33'(r_dt);
        age_s   = age_sum[32] ? 32'hffff_ffff : age_sum[31:0];
        rs      = r_loop && (age_s >= r_rdata.limit);
        fx = r_pos[0];
        fy = r_pos[1];
        fz = r_pos[2];
        if (rs) begin
            fy = r_rst[1];
            if (r_mode != MODE_DROP && r_mode != MODE_RISE) begin
                fx = r_rst[0];
                fz = r_rst[2];
            end
        end
    end

    // next state and RAM write port
    always_comb begin
        n_state = r_state;
        w_we    = 1'b0;
        w_addr  = r_p;
        w_data  = r_rdata;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.action == ACT_LOAD && load_ok) begin
                        w_we   = 1'b1;
                        w_addr = i_in.particle_index[AW-1:0];
                        w_data = '{cx: i_in.pos_x, cy: i_in.pos_y, cz: i_in.pos_z,
                                   rx: i_in.pos_x, ry: i_in.pos_y, rz: i_in.pos_z,
                                   speed: i_in.speed_value, limit: i_in.life_limit,
                                   age: 32'd0};
                    end else if (i_in.action == ACT_TICK) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD:   n_state = S_LAT;
            S_LAT:  n_state = S_STEP;
            S_STEP: begin
                if (r_mode == MODE_DROP || r_mode == MODE_RISE) begin
                    n_state = S_YMOVE;
                end else if (r_mode == MODE_SPREAD) begin
                    n_state = S_DIFF;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_YMOVE: n_state = S_APPLY;
            S_DIFF:  n_state = dzero ? S_APPLY : S_SQ;
            S_SQ:    n_state = (r_ax == 2'd2) ? S_SQRT : S_SQ;
            S_SQRT:  n_state = r_bit[0] ? S_DIV : S_SQRT;
            S_DIV:   n_state = (r_cnt == 5'd0) ? S_MUL : S_DIV;
            S_MUL:   n_state = S_ADD;
            S_ADD:   n_state = (r_ax == 2'd2) ? S_APPLY : S_DIV;
            S_APPLY: begin
                if (out_free) begin
                    w_we   = 1'b1;
                    w_data.cx  = fx;
                    w_data.cy  = fy;
                    w_data.cz  = fz;
                    w_data.age = rs ? 32'd0 : age_s;
                    n_state = (r_p == AW'(NUM_PARTICLES - 1)) ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        r_rdata <= r_mem[r_p];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_DROP;
            r_loop      <= 1'b0;
            r_ctr       <= '0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < 3; c++) r_piv[c] <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MODE: r_mode <= i_cfg_data;
                    CFG_LOOP: r_loop <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == S_IDLE && in_acc) begin
                if (i_in.action == ACT_LOAD && load_ok) begin
                    r_ctr[i_in.particle_index[AW-1:0]] <= 1'b0;
                end else if (i_in.action == ACT_CENTER) begin
                    // pivot doubles as every slot's restart point until reloaded
                    r_ctr    <= '1;
                    r_piv[0] <= i_in.pos_x;
                    r_piv[1] <= i_in.pos_y;
                    r_piv[2] <= i_in.pos_z;
                end
            end
            if (r_state == S_APPLY && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_p  <= '0;
                r_dt <= i_in.time_step;
            end
            S_LAT: begin
                r_pos[0] <= r_rdata.cx;
                r_pos[1] <= r_rdata.cy;
                r_pos[2] <= r_rdata.cz;
                r_rst[0] <= r_ctr[r_p] ? r_piv[0] : r_rdata.rx;
                r_rst[1] <= r_ctr[r_p] ? r_piv[1] : r_rdata.ry;
                r_rst[2] <= r_ctr[r_p] ? r_piv[2] : r_rdata.rz;
            end
            S_STEP: r_step <= step_prod[52:16];
            S_YMOVE: r_pos[1] <= sat32(ysum);
            S_DIFF: begin
                for (int c = 0; c < 3; c++) begin
                    r_mag[c] <= 31'(dmag[c] >> sh);
                    r_neg[c] <= dif[c][32];
                end
                r_ax  <= 2'd0;
                r_sum <= '0;
            end
            S_SQ: begin
                r_sum <= r_sum + 64'(sq);
                if (r_ax == 2'd2) begin
                    r_ax  <= 2'd0;
                    r_n   <= r_sum + 64'(sq);
                    r_res <= '0;
                    r_bit <= 64'h4000_0000_0000_0000;
                end else begin
                    r_ax  <= r_ax + 2'd1;
                end
            end
            S_SQRT: begin
                r_n   <= n_nx;
                r_res <= res_nx;
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_len <= res_nx[31:0];
                    r_ax  <= 2'd0;
                    r_rem <= 32'(r_mag[0] >> 1);
                    r_q   <= '0;
                    r_cnt <= 5'd16;
                end
            end
            S_DIV: begin
                r_rem <= rem_nx;
                r_q   <= q_nx;
                r_cnt <= r_cnt - 5'd1;
                r_u   <= r_neg[r_ax] ? -$signed({1'b0, q_nx}) : $signed({1'b0, q_nx});
            end
            S_MUL: r_prod <= mv_prod;
            S_ADD: begin
                r_pos[r_ax] <= sat32(asum);
                if (r_ax != 2'd2) begin
                    r_ax  <= r_ax + 2'd1;
                    r_rem <= 32'(r_mag[r_ax + 2'd1] >> 1);
                    r_q   <= '0;
                    r_cnt <= 5'd16;
                end
            end
            S_APPLY: begin
                if (out_free) begin
                    r_p <= r_p + AW'(1);
                    r_out.out_index <= 6'(r_p);
                    r_out.out_x     <= fx;
                    r_out.out_y     <= fy;
                    r_out.out_z     <= fz;
                    r_out.out_age   <= rs ? 32'd0 : age_s;
                    r_out.restarted <= rs;
                    r_out.last_flag <= (r_p == AW'(NUM_PARTICLES - 1));
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/pmu_check.sv -----
`default_nettype none
`include "assert_macros.svh"
module pmu_check #(
    parameter int NUM_PARTICLES = pmu_pkg::NUM_PARTICLES_DEF
) (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_stall,
    input pmu_pkg::t_in_word   i_in,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input pmu_pkg::t_out_word  o_out
);
    import pmu_pkg::*;

    `AST_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `AST_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out))
    `AST_NXT(a_tick_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in.action == ACT_TICK, o_in_stall)
    `AST_IMP(a_last_idx, i_clk, i_rst_n, o_out_valid && o_out.last_flag, o_out.out_index == 6'(NUM_PARTICLES - 1))

endmodule

bind particle_motion_update_unit pmu_check #(.NUM_PARTICLES(NUM_PARTICLES)) u_pmu_check (.*);
`default_nettype wire
